@@ rtl/chv_pkg.sv @@
// Shared types, codes and the quarter-wave sine table for the circle Hough voter.
package chv_pkg;

  localparam int ANGLE_STEPS  = 360;
  localparam int HALF_TURN    = 180;
  localparam int QUARTER_TURN = 90;
  localparam int QUEUE_DEPTH  = 2;

  // input operation codes
  localparam logic [1:0] OP_VOTE  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_RADIUS    = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_WIDTH     = 2'd2;
  localparam logic [1:0] REG_HEIGHT    = 2'd3;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] edge_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  cell_x;
    logic [7:0]  cell_y;
    logic [15:0] vote_count;
    logic        is_circle;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  radius;
    logic [15:0] threshold;
    logic [8:0]  width;
    logic [8:0]  height;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_VOTE,
    CMD_READ,
    CMD_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] x;
    logic [7:0] y;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  typedef struct packed {
    logic init_clear;
    logic idle;
  } back_status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CLEAR,
    B_VOTE,
    B_DRAIN,
    B_RD_ISSUE,
    B_RD_WAIT
  } back_state_t;

  typedef logic signed [15:0] q14_t;
  typedef q14_t qtab_t [0:QUARTER_TURN];
  typedef logic [63:0] div_tab_t [0:9];

  localparam logic [63:0] PI_Q30    = 64'd3373259426;
  localparam int          Q30_SHIFT = 30;
  localparam div_tab_t    TAYLOR_DIV = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                         64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

  // round(16384*sin(d deg)) for d in 0..90, integer Taylor series at elaboration
  function automatic qtab_t build_quarter_sin();
    qtab_t              tab;
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [64:0] sum;
    for (int d = 0; d <= QUARTER_TURN; d++) begin
      x    = (64'(d) * PI_Q30) / 64'd180;
      term = x;
      sum  = $signed({1'b0, x});
      for (int k = 1; k <= 10; k++) begin
        term = (term * x) >> Q30_SHIFT;
        term = (term * x) >> Q30_SHIFT;
        term = term / TAYLOR_DIV[k-1];
        if (k[0]) begin
          sum = sum - $signed({1'b0, term});
        end else begin
          sum = sum + $signed({1'b0, term});
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      tab[d] = 16'((sum + 65'sd32768) >>> 16);
    end
    return tab;
  endfunction

  localparam qtab_t QUARTER_SIN = build_quarter_sin();

endpackage

@@ rtl/chv_front.sv @@
// Front end: request acceptance and classification into back-end commands.
module chv_front (
  input  logic                  start,
  output logic                  busy,
  input  chv_pkg::in_item_t     in_data,
  input  chv_pkg::fifo_status_t q_status,
  input  chv_pkg::back_status_t back_status,
  output chv_pkg::push_t        push
);

  logic accept;

  // hold off while the queue is full or the power-up sweep runs
  assign busy   = q_status.full || back_status.init_clear;
  assign accept = start && !busy;

  always_comb begin
    push.cmd.x    = in_data.pos_x;
    push.cmd.y    = in_data.pos_y;
    push.cmd.kind = chv_pkg::CMD_VOTE;
    push.push     = 1'b0;
    case (in_data.operation)
      chv_pkg::OP_VOTE: begin
        // drop non-edge pixels here, they cast no votes
        push.cmd.kind = chv_pkg::CMD_VOTE;
        push.push     = accept && (in_data.edge_value != 8'd0);
      end
      chv_pkg::OP_READ: begin
        push.cmd.kind = chv_pkg::CMD_READ;
        push.push     = accept;
      end
      chv_pkg::OP_CLEAR: begin
        push.cmd.kind = chv_pkg::CMD_CLEAR;
        push.push     = accept;
      end
      default: begin
        push.push = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/chv_cmd_fifo.sv @@
// Short command queue between the front end and the back end.
module chv_cmd_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  chv_pkg::push_t        push,
  input  logic                  pop,
  output chv_pkg::cmd_t         head,
  output chv_pkg::fifo_status_t status
);

  localparam int PW = $clog2(chv_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(chv_pkg::QUEUE_DEPTH + 1);

  chv_pkg::cmd_t  entry_r [0:chv_pkg::QUEUE_DEPTH-1];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [CW-1:0]  cnt_r;
  logic [CW-1:0]  cnt_nxt;

  assign head         = entry_r[rd_ptr_r];
  assign status.full  = (cnt_r == CW'(chv_pkg::QUEUE_DEPTH));
  assign status.empty = (cnt_r == '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push.push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push.push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push) begin
      entry_r[wr_ptr_r] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push.push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(chv_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(chv_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

@@ rtl/chv_back.sv @@
// Back end: angle sweep pipeline, accumulator memory, clear sweep and cell read.
module chv_back #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  chv_pkg::cfg_t         cfg,
  input  chv_pkg::fifo_status_t q_status,
  input  chv_pkg::cmd_t         q_head,
  output logic                  pop,
  output logic                  out_valid,
  output chv_pkg::out_item_t    out_data,
  output chv_pkg::back_status_t status
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0]         ADDR_LAST  = AW'(DEPTH - 1);
  localparam logic [8:0]            ANG_LAST   = 9'(chv_pkg::ANGLE_STEPS - 1);
  localparam logic [COUNT_BITS-1:0] CMAX       = {COUNT_BITS{1'b1}};
  localparam logic signed [24:0]    NEG_LIMIT  = -25'sd16384;

  // fold an angle onto the quarter table: {negate, index}
  function automatic logic [7:0] fold(input logic [8:0] d);
    logic [8:0] idx;
    logic       neg;
    idx = d;
    neg = 1'b0;
    if (d <= 9'(chv_pkg::QUARTER_TURN)) begin
      idx = d;
    end else if (d <= 9'(chv_pkg::HALF_TURN)) begin
      idx = 9'(chv_pkg::HALF_TURN) - d;
    end else if (d <= 9'(chv_pkg::HALF_TURN + chv_pkg::QUARTER_TURN)) begin
      idx = d - 9'(chv_pkg::HALF_TURN);
      neg = 1'b1;
    end else begin
      idx = 9'(chv_pkg::ANGLE_STEPS) - d;
      neg = 1'b1;
    end
    return {neg, idx[6:0]};
  endfunction

  chv_pkg::back_state_t state_r, state_nxt;

  logic                  init_r;
  logic [AW-1:0]         clr_r;
  logic [8:0]            ang_r;
  chv_pkg::cmd_t         cmd_r;
  logic                  in_store_r;

  logic [COUNT_BITS-1:0] mem [0:DEPTH-1];
  logic [COUNT_BITS-1:0] rdata_r;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [AW-1:0]         rd_addr;

  // sweep pipeline
  logic                  v1_r, v2_r, v3_r, v4_r, v5_r;
  chv_pkg::q14_t         sin1_r, cos1_r;
  logic signed [24:0]    mx2_r, my2_r;
  logic [9:0]            xc3_r, yc3_r;
  logic [AW-1:0]         a4_r, a5_r;
  logic                  wl_v_r;
  logic [AW-1:0]         wl_a_r;
  logic [COUNT_BITS-1:0] wl_d_r;

  logic [8:0]            cos_ang;
  logic [7:0]            sin_f, cos_f;
  chv_pkg::q14_t         sin_q, cos_q;
  logic signed [24:0]    vx, vy;
  logic [9:0]            xc, yc;
  logic                  x_ok, y_ok;
  logic [10:0]           w_lim, h_lim;
  logic [COUNT_BITS-1:0] base, inc;
  logic [31:0]           cnt32;

  // angle lookup
  always_comb begin
    cos_ang = ang_r + 9'(chv_pkg::QUARTER_TURN);
    if (cos_ang >= 9'(chv_pkg::ANGLE_STEPS)) begin
      cos_ang = cos_ang - 9'(chv_pkg::ANGLE_STEPS);
    end
    sin_f = fold(ang_r);
    cos_f = fold(cos_ang);
    sin_q = sin_f[7] ? -chv_pkg::QUARTER_SIN[sin_f[6:0]] : chv_pkg::QUARTER_SIN[sin_f[6:0]];
    cos_q = cos_f[7] ? -chv_pkg::QUARTER_SIN[cos_f[6:0]] : chv_pkg::QUARTER_SIN[cos_f[6:0]];
  end

  // centre: truncate toward zero, keep (-1,0) as 0, then range check
  always_comb begin
    w_lim = ({2'b00, cfg.width} > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : {2'b00, cfg.width};
    h_lim = ({2'b00, cfg.height} > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : {2'b00, cfg.height};
    vx    = $signed({3'b000, cmd_r.x, 14'd0}) - mx2_r;
    vy    = $signed({3'b000, cmd_r.y, 14'd0}) - my2_r;
    xc    = vx[24] ? 10'd0 : vx[23:14];
    yc    = vy[24] ? 10'd0 : vy[23:14];
    x_ok  = (vx > NEG_LIMIT) && ({1'b0, xc} < w_lim);
    y_ok  = (vy > NEG_LIMIT) && ({1'b0, yc} < h_lim);
  end

  // read-modify-write with one-back forwarding of the last write
  always_comb begin
    base = (wl_v_r && (wl_a_r == a5_r)) ? wl_d_r : rdata_r;
    inc  = (base == CMAX) ? base : base + COUNT_BITS'(1);
  end

  assign rd_addr = AW'(cmd_r.y) * AW'(MAX_WIDTH) + AW'(cmd_r.x);
  assign cnt32   = in_store_r ? 32'(rdata_r) : 32'd0;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      chv_pkg::B_IDLE: begin
        if (!q_status.empty) begin
          case (q_head.kind)
            chv_pkg::CMD_VOTE:  state_nxt = chv_pkg::B_VOTE;
            chv_pkg::CMD_READ:  state_nxt = chv_pkg::B_RD_ISSUE;
            chv_pkg::CMD_CLEAR: state_nxt = chv_pkg::B_CLEAR;
            default:            state_nxt = chv_pkg::B_IDLE;
          endcase
        end
      end
      chv_pkg::B_CLEAR: begin
        if (clr_r == ADDR_LAST) state_nxt = chv_pkg::B_IDLE;
      end
      chv_pkg::B_VOTE: begin
        if (ang_r == ANG_LAST) state_nxt = chv_pkg::B_DRAIN;
      end
      chv_pkg::B_DRAIN: begin
        if (!(v1_r || v2_r || v3_r || v4_r || v5_r)) state_nxt = chv_pkg::B_IDLE;
      end
      chv_pkg::B_RD_ISSUE: state_nxt = chv_pkg::B_RD_WAIT;
      chv_pkg::B_RD_WAIT:  state_nxt = chv_pkg::B_IDLE;
      default:             state_nxt = chv_pkg::B_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop        = 1'b0;
    mem_we     = v5_r;
    mem_waddr  = a5_r;
    mem_wdata  = inc;
    mem_raddr  = a4_r;
    status.idle       = 1'b0;
    status.init_clear = init_r;
    case (state_r)
      chv_pkg::B_IDLE: begin
        pop         = !q_status.empty;
        status.idle = 1'b1;
      end
      chv_pkg::B_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
      end
      chv_pkg::B_RD_ISSUE: begin
        mem_raddr = rd_addr;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  // payload stages
  always_ff @(posedge clk) begin
    sin1_r <= sin_q;
    cos1_r <= cos_q;
    mx2_r  <= $signed({1'b0, cfg.radius}) * cos1_r;
    my2_r  <= $signed({1'b0, cfg.radius}) * sin1_r;
    xc3_r  <= xc;
    yc3_r  <= yc;
    a4_r   <= AW'(yc3_r) * AW'(MAX_WIDTH) + AW'(xc3_r);
    a5_r   <= a4_r;
    wl_a_r <= a5_r;
    wl_d_r <= inc;
    if (pop) begin
      cmd_r      <= q_head;
      in_store_r <= (11'(q_head.x) < 11'(MAX_WIDTH)) && (11'(q_head.y) < 11'(MAX_HEIGHT));
    end
    if (state_r == chv_pkg::B_RD_WAIT) begin
      out_data.cell_x     <= cmd_r.x;
      out_data.cell_y     <= cmd_r.y;
      out_data.vote_count <= (cnt32 > 32'h0000_FFFF) ? 16'hFFFF : cnt32[15:0];
      out_data.is_circle  <= (cnt32 > {16'd0, cfg.threshold});
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= chv_pkg::B_CLEAR;
      init_r    <= 1'b1;
      clr_r     <= '0;
      ang_r     <= '0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      v5_r      <= 1'b0;
      wl_v_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      v1_r      <= (state_r == chv_pkg::B_VOTE);
      v2_r      <= v1_r;
      v3_r      <= v2_r && x_ok && y_ok;
      v4_r      <= v3_r;
      v5_r      <= v4_r;
      wl_v_r    <= v5_r;
      out_valid <= (state_r == chv_pkg::B_RD_WAIT);
      if (state_r == chv_pkg::B_CLEAR) begin
        if (clr_r == ADDR_LAST) begin
          clr_r  <= '0;
          init_r <= 1'b0;
        end else begin
          clr_r <= clr_r + 1'b1;
        end
      end
      if (state_r == chv_pkg::B_VOTE) begin
        ang_r <= (ang_r == ANG_LAST) ? '0 : ang_r + 1'b1;
      end
    end
  end

endmodule

@@ rtl/circle_hough_vote_accumulator.sv @@
// Top level of the fixed-radius circle Hough vote accumulator.
// Vote request: in the back end, pop, one sweep over all 360 angle steps, then drain;
//   the pipelined read-modify-write into the accumulator sets one vote per cycle.
// Read request: cell read in B_RD_ISSUE, result in B_RD_WAIT; clear: zeroes all cells.
// A two-entry queue lets the front accept requests while the back end works; busy rises
//   when it is full. The receiver cannot stall: out_valid is a one-cycle strobe.
// Reset: synchronous, active low; afterwards a sweep zeroing all cells keeps busy high.
module circle_hough_vote_accumulator #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int COUNT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               start,
  output logic               busy,
  input  chv_pkg::in_item_t  in_data,
  // result channel
  output logic               out_valid,
  output chv_pkg::out_item_t out_data,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  chv_pkg::cfg_t         cfg_r;
  chv_pkg::push_t        push;
  chv_pkg::fifo_status_t q_status;
  chv_pkg::cmd_t         q_head;
  chv_pkg::back_status_t back_status;
  logic                  pop;

  // Config writes land at once; user issues them only while the block is idle (unenforced).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radius    <= 8'd43;
      cfg_r.threshold <= 16'd120;
      cfg_r.width     <= 9'd256;
      cfg_r.height    <= 9'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        chv_pkg::REG_RADIUS:    cfg_r.radius    <= cfg_data[7:0];
        chv_pkg::REG_THRESHOLD: cfg_r.threshold <= cfg_data;
        chv_pkg::REG_WIDTH:     cfg_r.width     <= cfg_data[8:0];
        chv_pkg::REG_HEIGHT:    cfg_r.height    <= cfg_data[8:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // Front: accept and classify; drop zero-edge votes and the unused code.
  chv_front u_front (
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .q_status    (q_status),
    .back_status (back_status),
    .push        (push)
  );

  // Queue: decouple request acceptance from the long back-end sweeps.
  chv_cmd_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .pop    (pop),
    .head   (q_head),
    .status (q_status)
  );

  // Back: run one command at a time against the accumulator memory.
  chv_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_status  (q_status),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .status    (back_status)
  );

  // A read passes B_RD_ISSUE, B_RD_WAIT, then B_IDLE, so strobes never come back to back.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // Never push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.push |-> !q_status.full)
    else $error("command pushed into full queue");

  // A result follows a cycle in which the back end was working on a read.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(!back_status.idle && !back_status.init_clear))
    else $error("result without a read in progress");

endmodule

@@ tb/tb_circle_hough_vote_accumulator.sv @@
// Self-checking testbench for the fixed-radius circle Hough vote accumulator.
module tb_circle_hough_vote_accumulator;
  timeunit 1ns;
  timeprecision 1ps;

  // operation code the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int          GRID        = 256;       // accumulator is GRID x GRID
  localparam int          Q14_ONE     = 16384;
  localparam int          ITEM_GOAL   = 850;
  localparam int          SAT_VOTES   = 184;       // 184 * 360 votes pass 65535
  localparam int          CYCLE_LIMIT = 4_000_000;
  localparam int          SETTLE_GAP  = 8;
  localparam int          END_GAP     = 400;       // one vote pass plus drain
  localparam real         PI_VALUE    = 3.14159265358979;

  // Tracks the accumulator contents and configuration; holds the reads that are due.
  class vote_tally_checker;
    bit [15:0]          tally [0:GRID*GRID-1];
    int                 sine_q14 [0:chv_pkg::ANGLE_STEPS-1];
    bit [7:0]           radius;
    bit [15:0]          threshold;
    bit [8:0]           width;
    bit [8:0]           height;
    chv_pkg::out_item_t awaiting_reads [$];
    int                 errors;
    int                 reads_checked;
    int                 circles_seen;

    function new();
      longint unsigned x;
      longint unsigned term;
      longint          sum;
      int              quarter [0:chv_pkg::QUARTER_TURN];
      for (int d = 0; d <= chv_pkg::QUARTER_TURN; d++) begin
        // Taylor series of sin in Q30, rounded to nearest Q14
        x    = longint'(d) * chv_pkg::PI_Q30 / 180;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 10; k++) begin
          term = (term * x) >> 30;
          term = (term * x) >> 30;
          term = term / longint'((2 * k) * (2 * k + 1));
          if (k % 2 == 1) sum = sum - longint'(term);
          else sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        quarter[d] = int'((sum + 32768) >>> 16);
      end
      // unfold the quarter wave into a full turn
      for (int d = 0; d < chv_pkg::ANGLE_STEPS; d++) begin
        if (d <= chv_pkg::QUARTER_TURN) sine_q14[d] = quarter[d];
        else if (d <= chv_pkg::HALF_TURN) sine_q14[d] = quarter[chv_pkg::HALF_TURN - d];
        else if (d <= chv_pkg::HALF_TURN + chv_pkg::QUARTER_TURN)
          sine_q14[d] = -quarter[d - chv_pkg::HALF_TURN];
        else sine_q14[d] = -quarter[chv_pkg::ANGLE_STEPS - d];
      end
      radius    = 8'd43;
      threshold = 16'd120;
      width     = 9'd256;
      height    = 9'd256;
      errors    = 0;
    endfunction

    function void write_register(logic [1:0] index, logic [15:0] value);
      case (index)
        chv_pkg::REG_RADIUS:    radius    = value[7:0];
        chv_pkg::REG_THRESHOLD: threshold = value;
        chv_pkg::REG_WIDTH:     width     = value[8:0];
        chv_pkg::REG_HEIGHT:    height    = value[8:0];
        default: ;
      endcase
    endfunction

    function void note_request(chv_pkg::in_item_t req);
      chv_pkg::out_item_t due;
      int                 w;
      int                 h;
      int                 cx;
      int                 cy;
      int                 idx;
      case (req.operation)
        chv_pkg::OP_CLEAR: begin
          foreach (tally[i]) tally[i] = '0;
        end
        chv_pkg::OP_READ: begin
          due.cell_x     = req.pos_x;
          due.cell_y     = req.pos_y;
          due.vote_count = tally[{req.pos_y, req.pos_x}];
          due.is_circle  = (due.vote_count > threshold);
          awaiting_reads.push_back(due);
        end
        chv_pkg::OP_VOTE: begin
          if (req.edge_value != 8'd0) begin
            w = (width > GRID) ? GRID : int'(width);
            h = (height > GRID) ? GRID : int'(height);
            for (int t = 0; t < chv_pkg::ANGLE_STEPS; t++) begin
              // signed division truncates toward zero, as the block does
              cx = (int'(req.pos_x) * Q14_ONE
                    - int'(radius) * sine_q14[(t + chv_pkg::QUARTER_TURN) % chv_pkg::ANGLE_STEPS])
                   / Q14_ONE;
              cy = (int'(req.pos_y) * Q14_ONE - int'(radius) * sine_q14[t]) / Q14_ONE;
              if (cx >= 0 && cy >= 0 && cx < w && cy < h) begin
                idx = cy * GRID + cx;
                if (tally[idx] != 16'hFFFF) tally[idx] = tally[idx] + 16'd1;
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_read(chv_pkg::out_item_t got);
      chv_pkg::out_item_t due;
      if (awaiting_reads.size() == 0) begin
        errors++;
        $display("%0t: read result with none pending: x=%0d y=%0d count=%0d circle=%0b",
                 $time, got.cell_x, got.cell_y, got.vote_count, got.is_circle);
        return;
      end
      due = awaiting_reads.pop_front();
      reads_checked++;
      if (due.is_circle) circles_seen++;
      if (got !== due) begin
        errors++;
        $display("%0t: read mismatch expected x=%0d y=%0d count=%0d circle=%0b",
                 $time, due.cell_x, due.cell_y, due.vote_count, due.is_circle);
        $display("%0t:                 actual x=%0d y=%0d count=%0d circle=%0b",
                 $time, got.cell_x, got.cell_y, got.vote_count, got.is_circle);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  chv_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  chv_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = chv_pkg::REG_RADIUS;
  logic [15:0]        cfg_data = '0;

  vote_tally_checker scoreboard;
  int  cycle_count = 0;
  bit  steady = 1'b0;       // set to suppress sender idling for a whole phase
  int  requests_sent = 0;   // votes with an edge, reads and clears
  int  votes_sent = 0;
  int  clears_sent = 0;
  int  ignored_sent = 0;
  int  cfg_writes = 0;
  int  phase_count = 0;
  bit [7:0] sat_x = 8'd0;
  bit [7:0] sat_y = 8'd0;

  circle_hough_vote_accumulator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Check every strobed read result; the strobe lasts one cycle and cannot be held off.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      scoreboard.check_read(out_data);
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("run stopped at cycle limit %0d with %0d reads pending", CYCLE_LIMIT,
               scoreboard.awaiting_reads.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Pick an idle gap: about 19 in 100 requests wait, none while steady is set.
  function automatic int pick_gap();
    if (!steady && $urandom_range(0, 99) < 19) return $urandom_range(1, 8);
    return 0;
  endfunction

  // Present one request and hold it until the block takes it (start high, busy low).
  // Keep start high across back-to-back requests so it never drops and rises in one step.
  task automatic send_request(input chv_pkg::in_item_t req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      in_data <= chv_pkg::in_item_t'($urandom);
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy !== 1'b0);
    scoreboard.note_request(req);
    case (req.operation)
      chv_pkg::OP_READ:  requests_sent++;
      chv_pkg::OP_CLEAR: begin
        requests_sent++;
        clears_sent++;
      end
      chv_pkg::OP_VOTE: begin
        if (req.edge_value != 8'd0) begin
          requests_sent++;
          votes_sent++;
        end else begin
          ignored_sent++;
        end
      end
      default: ignored_sent++;
    endcase
  endtask

  task automatic send_op(input logic [1:0] op, input int x, input int y, input int edge_val);
    chv_pkg::in_item_t req;
    req.operation  = op;
    req.pos_x      = 8'(x);
    req.pos_y      = 8'(y);
    req.edge_value = 8'(edge_val);
    send_request(req);
  endtask

  // Write one register; hold cfg_valid across back-to-back writes.
  task automatic write_register(input logic [1:0] index, input logic [15:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    scoreboard.write_register(index, value);
    cfg_writes++;
  endtask

  // Every phase ends on a read, so once no read is pending the back end is empty;
  // then leave a short margin, retune all four registers and release the port.
  task automatic reconfigure(input int r, input int thr, input int w, input int h);
    logic [15:0] junk;
    start <= 1'b0;
    while (scoreboard.awaiting_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
    // fill the unused upper data bits at random; the block keeps only the low bits
    junk = 16'($urandom);
    write_register(chv_pkg::REG_RADIUS, {junk[15:8], 8'(r)});
    write_register(chv_pkg::REG_THRESHOLD, 16'(thr));
    write_register(chv_pkg::REG_WIDTH, {junk[6:0], 9'(w)});
    write_register(chv_pkg::REG_HEIGHT, {junk[14:8], 9'(h)});
    cfg_valid <= 1'b0;
    phase_count++;
  endtask

  // A well-formed burst: edge pixels on one circle around a centre, then reads of the
  // centre and a few cells next to it.
  task automatic circle_burst();
    int  w_lim;
    int  h_lim;
    int  cx;
    int  cy;
    int  px;
    int  py;
    int  nv;
    int  edge_val;
    real ang;
    w_lim = (scoreboard.width == 0 || scoreboard.width > GRID) ? GRID : int'(scoreboard.width);
    h_lim = (scoreboard.height == 0 || scoreboard.height > GRID) ? GRID
                                                                 : int'(scoreboard.height);
    cx = $urandom_range(0, w_lim - 1);
    cy = $urandom_range(0, h_lim - 1);
    nv = $urandom_range(3, 10);
    for (int i = 0; i < nv; i++) begin
      ang = real'($urandom_range(0, chv_pkg::ANGLE_STEPS - 1)) * PI_VALUE / 180.0;
      px  = cx + $rtoi($floor(real'(scoreboard.radius) * $cos(ang) + 0.5));
      py  = cy + $rtoi($floor(real'(scoreboard.radius) * $sin(ang) + 0.5));
      px  = (px < 0) ? 0 : (px > GRID - 1) ? GRID - 1 : px;
      py  = (py < 0) ? 0 : (py > GRID - 1) ? GRID - 1 : py;
      edge_val = ($urandom_range(0, 99) < 8) ? 0 : $urandom_range(1, 255);
      send_op(chv_pkg::OP_VOTE, px, py, edge_val);
    end
    send_op(chv_pkg::OP_READ, cx, cy, $urandom);
    repeat ($urandom_range(0, 2)) begin
      px = cx + $urandom_range(0, 2) - 1;
      py = cy + $urandom_range(0, 2) - 1;
      send_op(chv_pkg::OP_READ, (px < 0) ? 0 : px, (py < 0) ? 0 : py, $urandom);
    end
  endtask

  // Noise: any operation but clear, every field at random.
  task automatic stray_request();
    logic [1:0] op;
    case ($urandom_range(0, 2))
      0:       op = chv_pkg::OP_VOTE;
      1:       op = chv_pkg::OP_READ;
      default: op = OP_UNUSED;
    endcase
    send_op(op, $urandom, $urandom, ($urandom_range(0, 3) == 0) ? 0 : $urandom);
  endtask

  initial begin
    int r;
    int thr;
    int w;
    int h;
    int phase_start;
    scoreboard = new();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pass on the reset configuration (radius 43, threshold 120, full image).
    // The first request waits out the zeroing sweep that follows reset.
    send_op(chv_pkg::OP_VOTE, 0, 0, 8'h01);      // corner pixel, most centres fall off
    send_op(chv_pkg::OP_VOTE, 255, 255, 8'hFF);  // far corner, all edge bits set
    send_op(chv_pkg::OP_VOTE, 128, 128, 8'h00);  // zero edge casts no vote
    send_op(OP_UNUSED, 17, 99, 8'hAA);           // unused code is dropped
    send_op(chv_pkg::OP_VOTE, 100, 100, 8'h80);
    send_op(chv_pkg::OP_VOTE, 143, 100, 8'h55);  // circle passes through (100,100)
    send_op(chv_pkg::OP_READ, 57, 100, 8'h00);
    send_op(chv_pkg::OP_READ, 100, 100, 8'hFF);
    send_op(chv_pkg::OP_READ, 0, 0, 8'h00);
    send_op(chv_pkg::OP_READ, 255, 255, 8'h00);
    send_op(chv_pkg::OP_READ, 212, 212, 8'h00);
    send_op(chv_pkg::OP_READ, 0, 255, 8'h00);
    send_op(chv_pkg::OP_READ, 255, 0, 8'h00);
    send_op(OP_UNUSED, 255, 255, 8'hFF);
    send_op(chv_pkg::OP_CLEAR, 255, 255, 8'hFF); // clear ignores its fields
    send_op(chv_pkg::OP_READ, 57, 100, 8'h00);   // must be zero again
    send_op(chv_pkg::OP_VOTE, 43, 0, 8'h01);
    send_op(chv_pkg::OP_READ, 0, 0, 8'h00);
    send_op(chv_pkg::OP_READ, 86, 0, 8'h00);
    send_op(chv_pkg::OP_READ, 43, 0, 8'h00);

    // Random phases, each on its own configuration; the first ones hit the extremes.
    while (requests_sent < ITEM_GOAL) begin
      case (phase_count)
        0: begin r = 1;   thr = 0;     w = 256; h = 256; end
        1: begin r = 255; thr = 65535; w = 511; h = 511; end
        2: begin r = 20;  thr = 3;     w = 0;   h = 256; end  // every vote dropped
        3: begin r = 37;  thr = 5;     w = 1;   h = 1;   end
        4: begin r = 12;  thr = 2;     w = 257; h = 0;   end
        5: begin r = 0;   thr = 65534; w = 256; h = 256; end  // saturation run
        default: begin
          r   = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 60) : $urandom_range(0, 255);
          thr = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 12) : $urandom_range(0, 65535);
          w   = ($urandom_range(0, 9) < 8) ? $urandom_range(32, 256) : $urandom_range(0, 511);
          h   = ($urandom_range(0, 9) < 8) ? $urandom_range(32, 256) : $urandom_range(0, 511);
        end
      endcase
      reconfigure(r, thr, w, h);
      steady = (phase_count == 6 || phase_count == 10);
      phase_start = requests_sent;

      // revisit the saturated cell under each new threshold until it is cleared
      send_op(chv_pkg::OP_READ, sat_x, sat_y, $urandom);
      if (phase_count == 4 || phase_count == 9)
        send_op(chv_pkg::OP_CLEAR, $urandom, $urandom, $urandom);

      if (phase_count == 6) begin
        // radius zero puts all 360 votes on the pixel itself: drive one cell to the top
        sat_x = $urandom;
        sat_y = $urandom;
        for (int i = 0; i < SAT_VOTES; i++) begin
          send_op(chv_pkg::OP_VOTE, sat_x, sat_y, $urandom_range(1, 255));
          if (i == SAT_VOTES / 2) send_op(chv_pkg::OP_READ, sat_x, sat_y, $urandom);
        end
        send_op(chv_pkg::OP_READ, sat_x, sat_y, $urandom);
      end else begin
        while (requests_sent - phase_start < 60 && requests_sent < ITEM_GOAL) begin
          if ($urandom_range(0, 3) == 0) stray_request();
          else circle_burst();
        end
      end
      // close on a read so the next reconfigure can tell the back end has drained
      send_op(chv_pkg::OP_READ, $urandom, $urandom, $urandom);
    end

    start <= 1'b0;
    while (scoreboard.awaiting_reads.size() != 0) @(posedge clk);
    repeat (END_GAP) @(posedge clk);

    if (scoreboard.awaiting_reads.size() != 0) begin
      scoreboard.errors += scoreboard.awaiting_reads.size();
      $display("%0t: %0d read results never arrived", $time,
               scoreboard.awaiting_reads.size());
    end
    $display("Covered %0d requests (%0d votes, %0d clears, %0d ignored) over %0d settings,",
             requests_sent, votes_sent, clears_sent, ignored_sent, phase_count + 1);
    $display("%0d register writes; %0d reads checked, %0d above threshold, %0d errors.",
             cfg_writes, scoreboard.reads_checked, scoreboard.circles_seen, scoreboard.errors);
    if (scoreboard.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ circle_hough_vote_accumulator.f @@
rtl/chv_pkg.sv
rtl/chv_front.sv
rtl/chv_cmd_fifo.sv
rtl/chv_back.sv
rtl/circle_hough_vote_accumulator.sv
tb/tb_circle_hough_vote_accumulator.sv
